### rtl/ghe_pkg.sv
`default_nettype none
package ghe_pkg;

   typedef enum logic [1:0] {
      CMD_EVENT      = 2'd0,
      CMD_WRITE_GATE = 2'd1,
      CMD_READ_COUNT = 2'd2,
      CMD_NONE       = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      REG_GATE_MODE   = 3'd0,
      REG_GATE_GAIN   = 3'd1,
      REG_GATE_OFFSET = 3'd2,
      REG_SORT_GAIN   = 3'd3,
      REG_SORT_OFFSET = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EV_MUL,
      ST_EV_SUM,
      ST_EV_DECIDE,
      ST_SCAN,
      ST_RMW,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_RESP
   } state_type;

   localparam int VALUE_W = 32;
   localparam int GAIN_W  = 24;
   localparam int SUM_W   = 58;
   localparam int FRAC_W  = 24;
   localparam int ALIGN_W = 16;
   localparam int MASK_W  = 8;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_OUTSIDE = 1'b1;

endpackage
`default_nettype wire

### rtl/gated_histogram_engine.sv
`default_nettype none
// Gated histogram engine. A command is taken when start is high and busy is
// low; exactly one result beat follows on rsp_valid for one cycle and the
// receiver cannot stall it. After reset the counter memory is swept to zero
// with busy high throughout. An event whose bin lies outside the histogram or
// that chooses no spectrum goes straight to its result; otherwise the engine
// scans every spectrum in turn and does a read-modify-write for each chosen
// spectrum, one at a time, through the single write port of the counter
// memory. Configuration writes may be made at any idle time.
module gated_histogram_engine #(
   parameter int NUM_SPECTRA = 8,
   parameter int NUM_BINS    = 32768
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_sort_value,
   input  wire logic [31:0] req_gate_value,
   input  wire logic [2:0]  req_spectrum_index,
   input  wire logic [14:0] req_bin_index,
   input  wire logic [31:0] req_bound_first,
   input  wire logic [31:0] req_bound_second,
   output logic             rsp_valid,
   output logic             rsp_status,
   output logic [7:0]       rsp_hit_mask,
   output logic [31:0]      rsp_count,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   import ghe_pkg::*;

   localparam int DEPTH = NUM_SPECTRA * NUM_BINS;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = (NUM_SPECTRA > 1) ? $clog2(NUM_SPECTRA) : 1;
   localparam int BW    = $clog2(NUM_BINS);

   state_type state_ff, state_in;

   logic                      gate_mode_ff;
   logic signed [GAIN_W-1:0]  gate_gain_ff, sort_gain_ff;
   logic signed [VALUE_W-1:0] gate_offset_ff, sort_offset_ff;

   logic signed [VALUE_W-1:0] bound_first_ff [NUM_SPECTRA];
   logic signed [VALUE_W-1:0] bound_second_ff [NUM_SPECTRA];

   logic signed [VALUE_W-1:0] sort_ff, gate_ff;
   logic signed [SUM_W-1:0]   sort_sum, gate_sum;

   logic [AW-1:0]          clr_ff, addr_ff, addr_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [BW-1:0]          bin_ff, bin_in;
   logic [NUM_SPECTRA-1:0] chosen_ff, chosen_in;
   logic                   status_ff, status_in;
   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic [31:0]            count_ff, count_in;
   logic                   rd_ok_ff, rd_ok_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr, scan_addr;
   logic [31:0]   ram_wdata, ram_rdata;

   logic [6:0]                 spec_ext;
   logic signed [SUM_W-1:0]    gate_adj;
   logic signed [SUM_W-FRAC_W-1:0] gidx;
   logic                       bin_ok;
   logic [NUM_SPECTRA-1:0]     chosen_c;
   logic                       last_k;

   ghe_scale u_sort_scale (
      .clock  (clock),
      .value  (sort_ff),
      .gain   (sort_gain_ff),
      .offset (sort_offset_ff),
      .sum    (sort_sum)
   );

   ghe_scale u_gate_scale (
      .clock  (clock),
      .value  (gate_ff),
      .gain   (gate_gain_ff),
      .offset (gate_offset_ff),
      .sum    (gate_sum)
   );

   ghe_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_counts (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign spec_ext  = {4'd0, req_spectrum_index};
   assign scan_addr = AW'(32'(k_ff) * 32'(NUM_BINS) + 32'(bin_ff));
   assign last_k    = (32'(k_ff) == 32'(NUM_SPECTRA - 1));

   always_comb begin
      gate_adj = gate_sum + ((gate_sum < 0) ? SUM_W'((64'd1 << FRAC_W) - 64'd1) : '0);
      gidx     = gate_adj[SUM_W-1:FRAC_W];
      bin_ok   = (sort_sum >= 0) &&
                 (sort_sum[SUM_W-1:FRAC_W] < (SUM_W-FRAC_W)'(NUM_BINS));
      for (int k = 0; k < NUM_SPECTRA; k++) begin
         if (!gate_mode_ff) begin
            chosen_c[k] = (gidx == (SUM_W-FRAC_W)'(k));
         end else if (bound_first_ff[k] > bound_second_ff[k]) begin
            chosen_c[k] = (gate_ff >= bound_second_ff[k]) && (gate_ff < bound_first_ff[k]);
         end else if (bound_second_ff[k] > bound_first_ff[k]) begin
            chosen_c[k] = (gate_ff >= bound_first_ff[k]) && (gate_ff < bound_second_ff[k]);
         end else begin
            chosen_c[k] = (gate_ff == bound_first_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         gate_mode_ff   <= 1'b0;
         gate_gain_ff   <= GAIN_W'(65536);
         gate_offset_ff <= '0;
         sort_gain_ff   <= GAIN_W'(65536);
         sort_offset_ff <= '0;
         for (int k = 0; k < NUM_SPECTRA; k++) begin
            bound_first_ff[k]  <= '0;
            bound_second_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_GATE_MODE:   gate_mode_ff   <= csr_write_data[0];
               REG_GATE_GAIN:   gate_gain_ff   <= csr_write_data[GAIN_W-1:0];
               REG_GATE_OFFSET: gate_offset_ff <= csr_write_data;
               REG_SORT_GAIN:   sort_gain_ff   <= csr_write_data[GAIN_W-1:0];
               REG_SORT_OFFSET: sort_offset_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && start && req_command == CMD_WRITE_GATE &&
             32'(spec_ext) < 32'(NUM_SPECTRA)) begin
            bound_first_ff[spec_ext[KW-1:0]]  <= req_bound_first;
            bound_second_ff[spec_ext[KW-1:0]] <= req_bound_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         sort_ff <= req_sort_value;
         gate_ff <= req_gate_value;
      end
      addr_ff   <= addr_in;
      k_ff      <= k_in;
      bin_ff    <= bin_in;
      chosen_ff <= chosen_in;
      status_ff <= status_in;
      mask_ff   <= mask_in;
      count_ff  <= count_in;
      rd_ok_ff  <= rd_ok_in;
   end

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      k_in      = k_ff;
      bin_in    = bin_ff;
      chosen_in = chosen_ff;
      status_in = status_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      rd_ok_in  = rd_ok_ff;
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = (ram_rdata == 32'hFFFF_FFFF) ? ram_rdata : ram_rdata + 32'd1;
      ram_raddr = addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (32'(clr_ff) == 32'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               status_in = STATUS_DONE;
               mask_in   = '0;
               count_in  = '0;
               case (req_command)
                  CMD_EVENT: state_in = ST_EV_MUL;
                  CMD_READ_COUNT: begin
                     rd_ok_in = (32'(spec_ext) < 32'(NUM_SPECTRA)) &&
                                (32'(req_bin_index) < 32'(NUM_BINS));
                     addr_in  = AW'(32'(spec_ext) * 32'(NUM_BINS) + 32'(req_bin_index));
                     state_in = ST_RD_ISSUE;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_EV_MUL: state_in = ST_EV_SUM;
         ST_EV_SUM: state_in = ST_EV_DECIDE;
         ST_EV_DECIDE: begin
            bin_in    = sort_sum[FRAC_W+BW-1:FRAC_W];
            chosen_in = chosen_c;
            k_in      = '0;
            if (!bin_ok) begin
               status_in = STATUS_OUTSIDE;
               state_in  = ST_RESP;
            end else begin
               for (int k = 0; k < MASK_W; k++) begin
                  if (k < NUM_SPECTRA) begin
                     mask_in[k] = chosen_c[k];
                  end
               end
               state_in = (chosen_c == '0) ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            ram_raddr = scan_addr;
            addr_in   = scan_addr;
            if (chosen_ff[k_ff]) begin
               state_in = ST_RMW;
            end else if (last_k) begin
               state_in = ST_RESP;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         ST_RMW: begin
            ram_we = 1'b1;
            if (last_k) begin
               state_in = ST_RESP;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_RD_ISSUE: state_in = ST_RD_DATA;
         ST_RD_DATA: begin
            count_in = rd_ok_ff ? ram_rdata : '0;
            state_in = ST_RESP;
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_status   = status_ff;
   assign rsp_hit_mask = mask_ff;
   assign rsp_count    = count_ff;

endmodule
`default_nettype wire

### rtl/ghe_ram.sv
`default_nettype none
module ghe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/ghe_scale.sv
`default_nettype none
module ghe_scale
(
   input  wire logic                                clock,
   input  wire logic signed [ghe_pkg::VALUE_W-1:0] value,
   input  wire logic signed [ghe_pkg::GAIN_W-1:0]  gain,
   input  wire logic signed [ghe_pkg::VALUE_W-1:0] offset,
   output logic signed      [ghe_pkg::SUM_W-1:0]   sum
);
   import ghe_pkg::*;

   logic signed [VALUE_W+GAIN_W-1:0] prod_ff;
   logic signed [VALUE_W-1:0]        offset_ff;

   always_ff @(posedge clock) begin
      prod_ff   <= value * gain;
      offset_ff <= offset;
      sum       <= SUM_W'(prod_ff) + (SUM_W'(offset_ff) <<< ALIGN_W);
   end
endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
   import ghe_pkg::*;

   localparam int SPECTRA   = 8;
   localparam int BINS      = 32768;
   localparam int CYCLE_CAP = 1_500_000;
   localparam int PHASES    = 8;
   localparam int PER_PHASE = 225;

   typedef struct {
      command_type cmd;
      logic [31:0] sort_word;
      logic [31:0] gate_word;
      logic [2:0]  spectrum;
      logic [14:0] bin;
      logic [31:0] bound_a;
      logic [31:0] bound_b;
   } command_beat;

   typedef struct {
      logic        status;
      logic [7:0]  hit_mask;
      logic [31:0] count;
   } result_beat;

   typedef struct {
      command_beat beat;
      logic        typed;
      result_beat  want;
   } directed_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]  req_command = '0;
   logic [31:0] req_sort_value = '0;
   logic [31:0] req_gate_value = '0;
   logic [2:0]  req_spectrum_index = '0;
   logic [14:0] req_bin_index = '0;
   logic [31:0] req_bound_first = '0;
   logic [31:0] req_bound_second = '0;
   logic        rsp_valid;
   logic        rsp_status;
   logic [7:0]  rsp_hit_mask;
   logic [31:0] rsp_count;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;

   gated_histogram_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_sort_value(req_sort_value),
      .req_gate_value(req_gate_value), .req_spectrum_index(req_spectrum_index),
      .req_bin_index(req_bin_index), .req_bound_first(req_bound_first),
      .req_bound_second(req_bound_second), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_hit_mask(rsp_hit_mask), .rsp_count(rsp_count),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // Model copy of the block's state and registers.
   int unsigned        hist_counts[int];
   logic signed [31:0] win_first[SPECTRA];
   logic signed [31:0] win_second[SPECTRA];
   logic               mode_custom = 1'b0;
   logic signed [23:0] gate_gain = 24'sd65536;
   logic signed [31:0] gate_offset = '0;
   logic signed [23:0] sort_gain = 24'sd65536;
   logic signed [31:0] sort_offset = '0;

   result_beat pending_results[$];
   bit  failed = 0;
   int  cycles = 0;
   int  n_events = 0, n_hits = 0, n_outside = 0, n_reads = 0, n_nonzero_reads = 0;

   function automatic result_beat bin_event(command_beat b);
      result_beat r;
      longint s, g, gidx;
      longint bin_no;
      logic chosen;
      int key;
      r = '{status: STATUS_DONE, hit_mask: '0, count: '0};
      case (b.cmd)
         CMD_EVENT: begin
            s = longint'($signed(b.sort_word)) * longint'(sort_gain)
                + longint'(sort_offset) * 65536;
            if (s < 0 || (s >>> 24) >= BINS) begin
               r.status = STATUS_OUTSIDE;
            end else begin
               bin_no = s >>> 24;
               g = longint'($signed(b.gate_word)) * longint'(gate_gain)
                   + longint'(gate_offset) * 65536;
               gidx = g / 64'sd16777216;
               for (int k = 0; k < SPECTRA; k++) begin
                  if (!mode_custom) begin
                     chosen = (gidx == k);
                  end else if (win_first[k] > win_second[k]) begin
                     chosen = $signed(b.gate_word) >= win_second[k] &&
                              $signed(b.gate_word) < win_first[k];
                  end else if (win_second[k] > win_first[k]) begin
                     chosen = $signed(b.gate_word) >= win_first[k] &&
                              $signed(b.gate_word) < win_second[k];
                  end else begin
                     chosen = $signed(b.gate_word) == win_first[k];
                  end
                  if (chosen) begin
                     key = k * BINS + int'(bin_no);
                     if (!hist_counts.exists(key)) hist_counts[key] = 0;
                     if (hist_counts[key] != 32'hFFFF_FFFF) hist_counts[key]++;
                     r.hit_mask[k] = 1'b1;
                  end
               end
            end
         end
         CMD_WRITE_GATE: begin
            win_first[b.spectrum]  = b.bound_a;
            win_second[b.spectrum] = b.bound_b;
         end
         CMD_READ_COUNT: begin
            key = int'(b.spectrum) * BINS + int'(b.bin);
            if (hist_counts.exists(key)) r.count = hist_counts[key];
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic issue_command(command_beat b, logic typed, result_beat want);
      result_beat r;
      logic       was_busy;
      req_command        <= b.cmd;
      req_sort_value     <= b.sort_word;
      req_gate_value     <= b.gate_word;
      req_spectrum_index <= b.spectrum;
      req_bin_index      <= b.bin;
      req_bound_first    <= b.bound_a;
      req_bound_second   <= b.bound_b;
      start              <= 1'b1;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      r = bin_event(b);
      if (b.cmd == CMD_EVENT) begin
         n_events++;
         if (r.hit_mask != 0) n_hits++;
         if (r.status == STATUS_OUTSIDE) n_outside++;
      end
      if (b.cmd == CMD_READ_COUNT) begin
         n_reads++;
         if (r.count != 0) n_nonzero_reads++;
      end
      pending_results.push_back(typed ? want : r);
   endtask

   task automatic idle_gap(bit allow);
      int pick, gap;
      pick = $urandom_range(0, 99);
      gap = !allow || pick < 65 ? 0 : (pick < 95 ? $urandom_range(1, 3)
                                                 : $urandom_range(8, 40));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_GATE_MODE:   mode_custom = data[0];
         REG_GATE_GAIN:   gate_gain   = data[23:0];
         REG_GATE_OFFSET: gate_offset = data;
         REG_SORT_GAIN:   sort_gain   = data[23:0];
         REG_SORT_OFFSET: sort_offset = data;
         default: ;
      endcase
   endtask

   function automatic directed_row row(command_type c, logic [31:0] sv, logic [31:0] gv,
                                       logic [2:0] sp, logic [14:0] bn,
                                       logic [31:0] ba, logic [31:0] bb,
                                       logic typed, logic st, logic [7:0] hm,
                                       logic [31:0] cnt);
      directed_row d;
      d.beat  = '{cmd: c, sort_word: sv, gate_word: gv, spectrum: sp, bin: bn,
                  bound_a: ba, bound_b: bb};
      d.typed = typed;
      d.want  = '{status: st, hit_mask: hm, count: cnt};
      return d;
   endfunction

   always @(negedge clock) begin
      result_beat w;
      if (rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: status %0d hit_mask %h count %0d",
                   rsp_status, rsp_hit_mask, rsp_count);
            failed = 1;
         end else begin
            w = pending_results.pop_front();
            if (rsp_status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp_status);
               failed = 1;
            end
            if (rsp_hit_mask !== w.hit_mask) begin
               $error("hit_mask: expected %h, got %h", w.hit_mask, rsp_hit_mask);
               failed = 1;
            end
            if (rsp_count !== w.count) begin
               $error("count: expected %0d, got %0d", w.count, rsp_count);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("gated_histogram_engine verification failed");
         $finish;
      end
   end

   initial begin
      directed_row table_rows[$];
      command_beat b;
      result_beat  none;
      int pick;
      logic [31:0] data;
      none = '{status: 1'b0, hit_mask: '0, count: '0};
      for (int k = 0; k < SPECTRA; k++) begin
         win_first[k] = '0;
         win_second[k] = '0;
      end

      table_rows.push_back(row(CMD_READ_COUNT, 0, 0, 0, 0, 0, 0, 1, 0, 8'h00, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h100, 32'h300, 0, 0, 0, 0, 1, 0, 8'h08, 0));
      table_rows.push_back(row(CMD_READ_COUNT, 0, 0, 3, 1, 0, 0, 1, 0, 8'h00, 1));
      table_rows.push_back(row(CMD_EVENT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1, 1, 8'h00, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 1, 8'h00, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h8000_0000, 0, 0, 0, 0, 0, 1, 1, 8'h00, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h007F_FF00, 0, 0, 0, 0, 0, 1, 0, 8'h01, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h0080_0000, 0, 0, 0, 0, 0, 1, 1, 8'h00, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h100, 32'h800, 0, 0, 0, 0, 1, 0, 8'h00, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h100, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, 8'h01, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h100, 32'hFFFF_FF00, 0, 0, 0, 0, 1, 0, 8'h00, 0));
      table_rows.push_back(row(CMD_EVENT, 32'h100, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 0, 8'h00, 0));
      table_rows.push_back(row(CMD_WRITE_GATE, 0, 0, 7, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                               1, 0, 8'h00, 0));
      table_rows.push_back(row(CMD_WRITE_GATE, 0, 0, 2, 0, 32'h500, 32'h500, 1, 0, 8'h00, 0));
      table_rows.push_back(row(CMD_READ_COUNT, 0, 0, 7, 15'h7FFF, 0, 0, 0, 0, 0, 0));
      table_rows.push_back(row(CMD_NONE, '1, '1, 3'h7, 15'h7FFF, '1, '1, 1, 0, 8'h00, 0));
      table_rows.push_back(row(CMD_READ_COUNT, 0, 0, 0, 15'h7FFF, 0, 0, 1, 0, 8'h00, 1));
      table_rows.push_back(row(CMD_READ_COUNT, 0, 0, 0, 1, 0, 0, 1, 0, 8'h00, 1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      foreach (table_rows[i]) begin
         issue_command(table_rows[i].beat, table_rows[i].typed, table_rows[i].want);
         idle_gap(1);
      end
      drain();

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            write_reg(REG_GATE_MODE, 0);
            write_reg(REG_GATE_GAIN, 32'h007F_FFFF);
            write_reg(REG_GATE_OFFSET, 32'h7FFF_FFFF);
            write_reg(REG_SORT_GAIN, 32'h007F_FFFF);
            write_reg(REG_SORT_OFFSET, 32'h8000_0000);
         end else if (p == 1) begin
            write_reg(REG_GATE_MODE, 1);
            write_reg(REG_GATE_GAIN, 32'h0080_0000);
            write_reg(REG_GATE_OFFSET, 32'h8000_0000);
            write_reg(REG_SORT_GAIN, 32'h0080_0000);
            write_reg(REG_SORT_OFFSET, 32'h7FFF_FFFF);
         end else begin
            write_reg(REG_GATE_MODE, p % 2);
            data = $urandom_range(32'h8000, 32'h20000);
            write_reg(REG_GATE_GAIN, $urandom_range(0, 3) == 0 ? -data : data);
            write_reg(REG_GATE_OFFSET, $urandom_range(0, 32'h800) - 32'h400);
            data = $urandom_range(32'hC000, 32'h14000);
            write_reg(REG_SORT_GAIN, data);
            write_reg(REG_SORT_OFFSET, p == 3 ? 32'h0 : $urandom_range(0, 32'h800));
         end
         for (int i = 0; i < PER_PHASE; i++) begin
            pick = $urandom_range(0, 99);
            b.sort_word = $urandom_range(0, 64 * 256 - 1);
            b.gate_word = $urandom_range(0, 32'hB00) - 32'h200;
            b.spectrum  = $urandom_range(0, 7);
            b.bin       = $urandom_range(0, 63);
            b.bound_a   = $urandom_range(0, 32'hC00) - 32'h200;
            b.bound_b   = $urandom_range(0, 3) == 0 ? b.bound_a
                                                    : $urandom_range(0, 32'hC00) - 32'h200;
            if (pick < 60) b.cmd = CMD_EVENT;
            else if (pick < 72) b.cmd = CMD_WRITE_GATE;
            else if (pick < 92) b.cmd = CMD_READ_COUNT;
            else begin
               b.cmd       = command_type'($urandom_range(0, 3));
               b.sort_word = $urandom;
               b.gate_word = $urandom;
               b.bin       = $urandom;
               b.bound_a   = $urandom;
               b.bound_b   = $urandom;
            end
            issue_command(b, 0, none);
            idle_gap(p != 3);
         end
         drain();
      end

      $display("Covered %0d events (%0d counted, %0d outside the histogram) and %0d reads",
               n_events, n_hits, n_outside, n_reads);
      $display("(%0d nonzero) over %0d register settings.", n_nonzero_reads, PHASES + 1);
      if (!failed) begin
         $display("gated_histogram_engine verification clean");
      end else begin
         $display("gated_histogram_engine verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
rtl/ghe_pkg.sv
rtl/ghe_ram.sv
rtl/ghe_scale.sv
rtl/gated_histogram_engine.sv
tb/tb.sv
